/* rtl/pcom_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pcom_pkg;

   // Grid geometry and number format.
   localparam int MAP_COLS        = 256;
   localparam int MAP_ROWS        = 256;
   localparam int COORD_FRAC_BITS = 10;
   localparam int CPM_FRAC_BITS   = 16;

   localparam int CELLS      = MAP_COLS * MAP_ROWS;
   localparam int COL_W      = $clog2(MAP_COLS);
   localparam int ROW_W      = $clog2(MAP_ROWS);
   localparam int CELL_SHIFT = COORD_FRAC_BITS + CPM_FRAC_BITS;
   localparam int PROD_W     = 56;

   // The grid is kept in words of WORD_W cells.
   localparam int WORD_W  = 64;
   localparam int WBIT_W  = $clog2(WORD_W);
   localparam int WORDS   = (CELLS + WORD_W - 1) / WORD_W;
   localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int IDX_W   = ($clog2(CELLS) > WBIT_W) ? $clog2(CELLS) : WBIT_W;

   // Actions.
   localparam logic [1:0] ACT_MARK  = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   // Status codes.
   localparam logic [2:0] ST_MARKED   = 3'd0;
   localparam logic [2:0] ST_HIGH     = 3'd1;
   localparam logic [2:0] ST_FAR      = 3'd2;
   localparam logic [2:0] ST_CLOSE    = 3'd3;
   localparam logic [2:0] ST_OFFMAP   = 3'd4;
   localparam logic [2:0] ST_DISABLED = 3'd5;
   localparam logic [2:0] ST_READ     = 3'd6;
   localparam logic [2:0] ST_CLEARED  = 3'd7;

   // Costs.
   localparam logic [7:0] COST_LETHAL  = 8'd254;
   localparam logic [7:0] COST_UNKNOWN = 8'd255;
   localparam logic [7:0] COST_FREE    = 8'd0;

   // Register indexes.
   localparam logic [2:0] CSR_ENABLED    = 3'd0;
   localparam logic [2:0] CSR_MAX_HEIGHT = 3'd1;
   localparam logic [2:0] CSR_MAX_RANGE  = 3'd2;
   localparam logic [2:0] CSR_MIN_RANGE  = 3'd3;
   localparam logic [2:0] CSR_ORIGIN_X   = 3'd4;
   localparam logic [2:0] CSR_ORIGIN_Y   = 3'd5;
   localparam logic [2:0] CSR_CPM        = 3'd6;
   localparam logic [2:0] CSR_TRACK      = 3'd7;

   // Register reset values.
   localparam logic [31:0] RST_MAX_HEIGHT = 32'd2048;
   localparam logic [30:0] RST_MAX_RANGE  = 31'd2560;
   localparam logic [30:0] RST_MIN_RANGE  = 31'd0;
   localparam logic [23:0] RST_CPM        = 24'd1310720;

endpackage

`default_nettype wire

/* rtl/point_cloud_obstacle_marker_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Path from acceptance to rsp_valid: a disabled mark or unused action goes straight to
// the response, an in-map read through a grid read, a rejected mark through five arithmetic
// steps, a mark that sets a cell through those steps and a read-modify-write of one grid
// word, and a clear through all WORDS words. The next word is accepted the cycle after
// the result is registered, even while it still waits for rsp_ready. After reset the grid
// memory is zeroed one word per cycle (WORDS = 1024 with the default map), req_ready low.
module point_cloud_obstacle_marker_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  wire         [1:0]  req_action,
   input  wire  signed [31:0] req_point_x,
   input  wire  signed [31:0] req_point_y,
   input  wire  signed [31:0] req_point_z,
   input  wire  signed [31:0] req_sensor_x,
   input  wire  signed [31:0] req_sensor_y,
   input  wire  signed [31:0] req_sensor_z,
   input  wire         [7:0]  req_read_col,
   input  wire         [7:0]  req_read_row,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output logic        [2:0]  rsp_status,
   output logic        [15:0] rsp_cell_index,
   output logic        [7:0]  rsp_cell_cost,
   input  wire                csr_we,
   input  wire         [2:0]  csr_index,
   input  wire         [31:0] csr_wdata
);

   localparam int PROD_W  = pcom_pkg::PROD_W;
   localparam int IDX_W   = pcom_pkg::IDX_W;
   localparam int WORD_W  = pcom_pkg::WORD_W;
   localparam int WADDR_W = pcom_pkg::WADDR_W;
   localparam int COL_W   = pcom_pkg::COL_W;
   localparam int ROW_W   = pcom_pkg::ROW_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF  = 4'd1;
   localparam logic [3:0] S_MUL   = 4'd2;
   localparam logic [3:0] S_ADD1  = 4'd3;
   localparam logic [3:0] S_ADD2  = 4'd4;
   localparam logic [3:0] S_CHECK = 4'd5;
   localparam logic [3:0] S_RD    = 4'd6;
   localparam logic [3:0] S_MOD   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;
   localparam logic [3:0] S_CLEAR = 4'd9;

   // Configuration registers.
   logic               enabled_ff;
   logic signed [31:0] max_height_ff;
   logic        [30:0] max_range_ff;
   logic        [30:0] min_range_ff;
   logic        [31:0] origin_x_ff;
   logic        [31:0] origin_y_ff;
   logic        [23:0] cpm_ff;
   logic               track_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff    <= 1'b1;
         max_height_ff <= pcom_pkg::RST_MAX_HEIGHT;
         max_range_ff  <= pcom_pkg::RST_MAX_RANGE;
         min_range_ff  <= pcom_pkg::RST_MIN_RANGE;
         origin_x_ff   <= '0;
         origin_y_ff   <= '0;
         cpm_ff        <= pcom_pkg::RST_CPM;
         track_ff      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            pcom_pkg::CSR_ENABLED:    enabled_ff    <= csr_wdata[0];
            pcom_pkg::CSR_MAX_HEIGHT: max_height_ff <= csr_wdata;
            pcom_pkg::CSR_MAX_RANGE:  max_range_ff  <= csr_wdata[30:0];
            pcom_pkg::CSR_MIN_RANGE:  min_range_ff  <= csr_wdata[30:0];
            pcom_pkg::CSR_ORIGIN_X:   origin_x_ff   <= csr_wdata;
            pcom_pkg::CSR_ORIGIN_Y:   origin_y_ff   <= csr_wdata;
            pcom_pkg::CSR_CPM:        cpm_ff        <= csr_wdata[23:0];
            pcom_pkg::CSR_TRACK:      track_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Control state.
   logic [3:0]         state_ff, state_in;
   logic [WADDR_W-1:0] clr_cnt_ff, clr_cnt_in;
   logic               clr_rsp_ff, clr_rsp_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Captured word.
   logic               is_read_ff;
   logic signed [31:0] pz_ff;
   logic        [31:0] px_ff, py_ff, sx_ff, sy_ff, sz_ff;

   // Result being built.
   logic [2:0]       res_status_ff, res_status_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       res_cost_ff, res_cost_in;

   // Output register.
   logic [2:0]  out_status_ff;
   logic [15:0] out_index_ff;
   logic [7:0]  out_cost_ff;

   // Arithmetic pipeline registers.
   logic [31:0]       magx_ff, magy_ff, magz_ff;
   logic              satx_ff, saty_ff, satz_ff;
   logic              high_ff;
   logic [31:0]       dcx_ff, dcy_ff;
   logic              negx_ff, negy_ff;
   logic [63:0]       sqx_ff, sqy_ff, sqz_ff;
   logic [PROD_W-1:0] prodx_ff, prody_ff;
   logic [63:0]       max2_ff, min2_ff;
   logic [63:0]       sum1_ff, dist_ff;
   logic              offmap_ff;
   logic [COL_W-1:0]  cell_col_ff;
   logic [ROW_W-1:0]  cell_row_ff;

   // Grid memory.
   logic [WORD_W-1:0]  grid_mem_ff [pcom_pkg::WORDS];
   logic [WORD_W-1:0]  rdata_ff;
   logic               mem_we;
   logic [WADDR_W-1:0] mem_waddr, mem_raddr;
   logic [WORD_W-1:0]  mem_wdata;
   logic               cell_bit;

   logic accept;
   logic out_free;
   logic [32:0] dx, dy, dz, mx, my, mz, dcx, dcy;
   logic [64:0] add1, add2;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = out_status_ff;
   assign rsp_cell_index = out_index_ff;
   assign rsp_cell_cost  = out_cost_ff;

   // Capture of the accepted word.
   always_ff @(posedge clock) begin
      if (accept) begin
         is_read_ff <= (req_action == pcom_pkg::ACT_READ);
         px_ff <= req_point_x;
         py_ff <= req_point_y;
         pz_ff <= req_point_z;
         sx_ff <= req_sensor_x;
         sy_ff <= req_sensor_y;
         sz_ff <= req_sensor_z;
      end
   end

   // Step 1: distances to the sensor and to the map corner.
   always_comb begin
      dx  = {px_ff[31], px_ff} - {sx_ff[31], sx_ff};
      dy  = {py_ff[31], py_ff} - {sy_ff[31], sy_ff};
      dz  = {pz_ff[31], pz_ff} - {sz_ff[31], sz_ff};
      mx  = dx[32] ? (~dx + 33'd1) : dx;
      my  = dy[32] ? (~dy + 33'd1) : dy;
      mz  = dz[32] ? (~dz + 33'd1) : dz;
      dcx = {px_ff[31], px_ff} - {origin_x_ff[31], origin_x_ff};
      dcy = {py_ff[31], py_ff} - {origin_y_ff[31], origin_y_ff};
   end

   always_ff @(posedge clock) begin
      // Step 1
      magx_ff <= mx[31:0];
      magy_ff <= my[31:0];
      magz_ff <= mz[31:0];
      satx_ff <= mx[32];
      saty_ff <= my[32];
      satz_ff <= mz[32];
      high_ff <= (pz_ff > max_height_ff);
      dcx_ff  <= dcx[31:0];
      dcy_ff  <= dcy[31:0];
      negx_ff <= dcx[32];
      negy_ff <= dcy[32];
      // Step 2: one multiplier per quantity. A magnitude of 2^32 saturates its square.
      sqx_ff   <= satx_ff ? '1 : 64'(magx_ff) * 64'(magx_ff);
      sqy_ff   <= saty_ff ? '1 : 64'(magy_ff) * 64'(magy_ff);
      sqz_ff   <= satz_ff ? '1 : 64'(magz_ff) * 64'(magz_ff);
      prodx_ff <= PROD_W'(dcx_ff) * PROD_W'(cpm_ff);
      prody_ff <= PROD_W'(dcy_ff) * PROD_W'(cpm_ff);
      max2_ff  <= 64'(max_range_ff) * 64'(max_range_ff);
      min2_ff  <= 64'(min_range_ff) * 64'(min_range_ff);
      // Step 3: first saturating add and the map bounds.
      sum1_ff     <= add1[64] ? '1 : add1[63:0];
      offmap_ff   <= negx_ff || negy_ff ||
                     ((prodx_ff >> pcom_pkg::CELL_SHIFT) >= PROD_W'(pcom_pkg::MAP_COLS)) ||
                     ((prody_ff >> pcom_pkg::CELL_SHIFT) >= PROD_W'(pcom_pkg::MAP_ROWS));
      cell_col_ff <= COL_W'(prodx_ff >> pcom_pkg::CELL_SHIFT);
      cell_row_ff <= ROW_W'(prody_ff >> pcom_pkg::CELL_SHIFT);
      // Step 4: second saturating add.
      dist_ff <= add2[64] ? '1 : add2[63:0];
   end

   assign add1 = 65'(sqx_ff) + 65'(sqy_ff);
   assign add2 = 65'(sum1_ff) + 65'(sqz_ff);

   // Grid memory: one read and one write port, read data registered.
   assign mem_raddr = WADDR_W'(idx_ff >> pcom_pkg::WBIT_W);
   assign cell_bit  = rdata_ff[idx_ff[pcom_pkg::WBIT_W-1:0]];

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = mem_raddr;
      mem_wdata = rdata_ff | (WORD_W'(1) << idx_ff[pcom_pkg::WBIT_W-1:0]);
      if (state_ff == S_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_cnt_ff;
         mem_wdata = '0;
      end else if (state_ff == S_MOD && !is_read_ff) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         grid_mem_ff[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= grid_mem_ff[mem_raddr];
   end

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      clr_cnt_in    = clr_cnt_ff;
      clr_rsp_in    = clr_rsp_ff;
      res_status_in = res_status_ff;
      idx_in        = idx_ff;
      res_cost_in   = res_cost_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_status_in = pcom_pkg::ST_DISABLED;
               idx_in        = '0;
               res_cost_in   = pcom_pkg::COST_FREE;
               case (req_action)
                  pcom_pkg::ACT_MARK: begin
                     state_in = enabled_ff ? S_DIFF : S_RESP;
                  end
                  pcom_pkg::ACT_READ: begin
                     if (int'(req_read_col) >= pcom_pkg::MAP_COLS ||
                         int'(req_read_row) >= pcom_pkg::MAP_ROWS) begin
                        res_status_in = pcom_pkg::ST_OFFMAP;
                        state_in      = S_RESP;
                     end else begin
                        res_status_in = pcom_pkg::ST_READ;
                        idx_in = IDX_W'(int'(req_read_row) * pcom_pkg::MAP_COLS +
                                        int'(req_read_col));
                        state_in = S_RD;
                     end
                  end
                  pcom_pkg::ACT_CLEAR: begin
                     res_status_in = pcom_pkg::ST_CLEARED;
                     clr_cnt_in    = '0;
                     clr_rsp_in    = 1'b1;
                     state_in      = S_CLEAR;
                  end
                  default: state_in = S_RESP;
               endcase
            end
         end
         S_DIFF:  state_in = S_MUL;
         S_MUL:   state_in = S_ADD1;
         S_ADD1:  state_in = S_ADD2;
         S_ADD2:  state_in = S_CHECK;
         S_CHECK: begin
            state_in = S_RESP;
            if (high_ff) begin
               res_status_in = pcom_pkg::ST_HIGH;
            end else if (dist_ff >= max2_ff) begin
               res_status_in = pcom_pkg::ST_FAR;
            end else if (dist_ff < min2_ff) begin
               res_status_in = pcom_pkg::ST_CLOSE;
            end else if (offmap_ff) begin
               res_status_in = pcom_pkg::ST_OFFMAP;
            end else begin
               res_status_in = pcom_pkg::ST_MARKED;
               idx_in = IDX_W'(int'(cell_row_ff) * pcom_pkg::MAP_COLS + int'(cell_col_ff));
               state_in = S_RD;
            end
         end
         S_RD: state_in = S_MOD;
         S_MOD: begin
            // A mark writes the word back with its bit set; a read only looks.
            if (!is_read_ff || cell_bit) begin
               res_cost_in = pcom_pkg::COST_LETHAL;
            end else begin
               res_cost_in = track_ff ? pcom_pkg::COST_UNKNOWN : pcom_pkg::COST_FREE;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + WADDR_W'(1);
            if (clr_cnt_ff == WADDR_W'(pcom_pkg::WORDS - 1)) begin
               state_in = clr_rsp_ff ? S_RESP : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         clr_rsp_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         clr_rsp_ff   <= clr_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      res_status_ff <= res_status_in;
      idx_ff        <= idx_in;
      res_cost_ff   <= res_cost_in;
      if (state_ff == S_RESP && out_free) begin
         out_status_ff <= res_status_ff;
         out_index_ff  <= 16'(idx_ff);
         out_cost_ff   <= res_cost_ff;
      end
   end

   // Checks.
   a_mark_cost: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && out_status_ff == pcom_pkg::ST_MARKED |->
         out_cost_ff == pcom_pkg::COST_LETHAL)
      else $error("marked word without lethal cost");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (out_status_ff == pcom_pkg::ST_HIGH ||
                       out_status_ff == pcom_pkg::ST_FAR ||
                       out_status_ff == pcom_pkg::ST_CLOSE ||
                       out_status_ff == pcom_pkg::ST_OFFMAP ||
                       out_status_ff == pcom_pkg::ST_DISABLED ||
                       out_status_ff == pcom_pkg::ST_CLEARED) |->
         out_index_ff == 16'd0 && out_cost_ff == pcom_pkg::COST_FREE)
      else $error("rejected word carries index or cost");

   a_write_owner: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> state_ff == S_CLEAR || (state_ff == S_MOD && !is_read_ff))
      else $error("grid written outside a mark or clear");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != S_IDLE)
      else $error("accepted word not processed");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_RESP && out_free |=> rsp_valid_ff && state_ff == S_IDLE)
      else $error("result not registered");

endmodule

`default_nettype wire
